// ----- hw/rtl/ust_pkg.sv -----
package ust_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_BIT_PERIOD = 2'd0;
    localparam logic [1:0] CFG_DATA_BITS  = 2'd1;
    localparam logic [1:0] CFG_PARITY     = 2'd2;
    localparam logic [1:0] CFG_TWO_STOP   = 2'd3;

    localparam int unsigned CFG_IDX_W = 2;

    // parity modes
    localparam logic [1:0] PAR_NONE = 2'd0;
    localparam logic [1:0] PAR_EVEN = 2'd1;
    localparam logic [1:0] PAR_ODD  = 2'd2;

    localparam logic [3:0] DATA_BITS_MIN   = 4'd5;
    localparam logic [3:0] DATA_BITS_MAX   = 4'd8;
    localparam logic [3:0] DATA_BITS_RESET = 4'd8;
    localparam int unsigned BIT_PERIOD_RESET = 5208;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] byte_data;
    } t_in_item;

    typedef struct packed {
        logic tx_line;
        logic busy_res;
        logic byte_taken;
    } t_out_item;

    // classified tick, as queued between front and back
    typedef struct packed {
        logic       offer;
        logic [7:0] data;     // already masked to the character width
        logic [3:0] nbits;    // effective data bits, 5..8
    } t_cmd;

    typedef struct packed {
        logic [1:0] parity_mode;
        logic       two_stop;
    } t_frame_cfg;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_START  = 5'b00010,
        ST_DATA   = 5'b00100,
        ST_PARITY = 5'b01000,
        ST_STOP   = 5'b10000
    } t_phase;

endpackage

// ----- hw/rtl/ust_front.sv -----
module ust_front
    import ust_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    input  logic [3:0] i_data_bits,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_pop
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic [1:0] n_count;
    logic [3:0] nbits;
    logic [7:0] mask;
    t_cmd       cmd;
    logic       push;
    logic       pop;

    // clamp the character width to 5..8
    always_comb begin
        priority if (i_data_bits < DATA_BITS_MIN) begin
            nbits = DATA_BITS_MIN;
        end else if (i_data_bits > DATA_BITS_MAX) begin
            nbits = DATA_BITS_MAX;
        end else begin
            nbits = i_data_bits;
        end
        mask      = 8'((9'd1 << nbits) - 9'd1);
        cmd.offer = i_in_data.byte_valid;
        cmd.data  = i_in_data.byte_data & mask;
        cmd.nbits = nbits;
    end

    assign o_in_stall  = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_mem[r_rd_ptr];
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cmd;
        end
    end

endmodule

// ----- hw/rtl/ust_engine.sv -----
module ust_engine
    import ust_pkg::*;
#(
    parameter int unsigned DIVIDER_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [DIVIDER_WIDTH-1:0] i_bit_period,
    input  t_frame_cfg               i_frame_cfg,
    input  logic                     i_cmd_valid,
    input  t_cmd                     i_cmd,
    output logic                     o_cmd_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_item                o_out_data
);

    localparam int unsigned TW = DIVIDER_WIDTH + 1;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_shift, n_shift;
    logic [3:0]  r_bits_left, n_bits_left;
    logic [TW-1:0] r_tick, n_tick;
    logic        r_parity, n_parity;
    logic        r_line, n_line;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [DIVIDER_WIDTH-1:0] period;
    logic [TW-1:0] cur_len;
    logic          taken;
    logic          step;

    assign step      = i_cmd_valid && (!r_out_valid || !i_out_stall);
    assign o_cmd_pop = step;

    always_comb begin
        period  = (i_bit_period == '0) ? DIVIDER_WIDTH'(1) : i_bit_period;
        cur_len = (r_phase == ST_STOP && i_frame_cfg.two_stop) ? {period, 1'b0}
                                                                : {1'b0, period};
    end

    always_comb begin
        n_phase     = r_phase;
        n_shift     = r_shift;
        n_bits_left = r_bits_left;
        n_tick      = r_tick;
        n_parity    = r_parity;
        n_line      = r_line;
        taken       = 1'b0;

        if (r_phase != ST_IDLE) begin
            if (r_tick >= cur_len) begin
                n_tick = TW'(1);
                unique case (r_phase)
                    ST_START: begin
                        n_line      = r_shift[0];
                        n_parity    = r_parity ^ r_shift[0];
                        n_shift     = r_shift >> 1;
                        n_bits_left = r_bits_left - 4'd1;
                        n_phase     = ST_DATA;
                    end
                    ST_DATA: begin
                        priority if (r_bits_left != 4'd0) begin
                            n_line      = r_shift[0];
                            n_parity    = r_parity ^ r_shift[0];
                            n_shift     = r_shift >> 1;
                            n_bits_left = r_bits_left - 4'd1;
                        end else if (i_frame_cfg.parity_mode == PAR_EVEN ||
                                     i_frame_cfg.parity_mode == PAR_ODD) begin
                            n_phase = ST_PARITY;
                            n_line  = r_parity ^ (i_frame_cfg.parity_mode == PAR_ODD);
                        end else begin
                            n_phase = ST_STOP;
                            n_line  = 1'b1;
                        end
                    end
                    ST_PARITY: begin
                        n_phase = ST_STOP;
                        n_line  = 1'b1;
                    end
                    default: begin
                        // end of stop level
                        n_phase = ST_IDLE;
                        n_line  = 1'b1;
                        n_tick  = '0;
                    end
                endcase
            end else begin
                n_tick = r_tick + TW'(1);
            end
        end

        // idle again on this tick: a byte may start right away
        if (n_phase == ST_IDLE) begin
            if (i_cmd.offer) begin
                n_shift     = i_cmd.data;
                n_bits_left = i_cmd.nbits;
                n_parity    = 1'b0;
                n_tick      = TW'(1);
                n_phase     = ST_START;
                n_line      = 1'b0;
                taken       = 1'b1;
            end else begin
                n_line = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ST_IDLE;
            r_shift     <= 8'd0;
            r_bits_left <= 4'd0;
            r_tick      <= '0;
            r_parity    <= 1'b0;
            r_line      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_phase     <= n_phase;
                r_shift     <= n_shift;
                r_bits_left <= n_bits_left;
                r_tick      <= n_tick;
                r_parity    <= n_parity;
                r_line      <= n_line;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out.tx_line    <= n_line;
            r_out.busy_res   <= (n_phase != ST_IDLE);
            r_out.byte_taken <= taken;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hw/rtl/uart_serial_transmitter_top.sv -----
// Serial transmitter, start bit, 5..8 data bits LSB first, optional parity,
// one or two stop periods. The line idles high.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): every transaction is
// one tick of the bit timer and may offer a byte (byte_valid). A byte offered
// while a frame is running is dropped.
// Output channel (o_out_valid / i_out_stall / o_out_data): exactly one
// transaction per input transaction, in order: line level, busy, byte taken.
//
// Each input transaction passes two registers on its way to the result: the
// queue entry and the frame engine's output register. Throughput: one
// transaction per cycle while the receiver does not stall the output.
// A stalled receiver holds the output register; the two-entry queue then
// fills and the input side stalls, with no transaction lost.
//
// Reset clears the queue and output register, idles the engine (line high)
// and loads defaults: 5208 ticks per bit, 8 data bits, no parity, one stop
// period. The user writes configuration only while idle (not enforced).
module uart_serial_transmitter_top
    import ust_pkg::*;
#(
    parameter int unsigned DIVIDER_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [DIVIDER_WIDTH-1:0] i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_item                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_item                o_out_data
);

    // configuration registers
    logic [DIVIDER_WIDTH-1:0] r_bit_period;
    logic [3:0]               r_data_bits;
    t_frame_cfg               r_frame_cfg;

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period          <= DIVIDER_WIDTH'(BIT_PERIOD_RESET);
            r_data_bits           <= DATA_BITS_RESET;
            r_frame_cfg.parity_mode <= PAR_NONE;
            r_frame_cfg.two_stop  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BIT_PERIOD: r_bit_period          <= i_cfg_wdata;
                CFG_DATA_BITS:  r_data_bits           <= i_cfg_wdata[3:0];
                CFG_PARITY:     r_frame_cfg.parity_mode <= i_cfg_wdata[1:0];
                CFG_TWO_STOP:   r_frame_cfg.two_stop  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // front: classify each tick and queue it
    ust_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_data_bits (r_data_bits),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // back: frame sequencer and bit timer
    ust_engine #(
        .DIVIDER_WIDTH (DIVIDER_WIDTH)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bit_period (r_bit_period),
        .i_frame_cfg  (r_frame_cfg),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

// ----- hw/rtl/ust_checker.sv -----
module ust_checker
    import ust_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // a taken byte starts the frame: busy and start bit low
    a_taken_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.byte_taken |-> o_out_data.busy_res && !o_out_data.tx_line)
        else $error("taken byte without start bit");

    // idle line rests high
    a_idle_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.busy_res |-> o_out_data.tx_line)
        else $error("line low while idle");

    // reset empties the output stage
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled transaction holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind uart_serial_transmitter_top ust_checker u_chk (.*);
